[design/tcte_pkg.sv]
// Shared types, constants and helpers for the text console teletype engine.
// No dependencies.
`default_nettype none
package tcte_pkg;

  localparam int STORE_ADDR_BITS_DEF = 14;
  localparam int CMD_QUEUE_DEPTH     = 2;

  localparam int CFG_IDX_BITS  = 3;
  localparam int FIELD_AW      = 14;

  localparam logic [CFG_IDX_BITS-1:0] REG_TEXT_START  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATTR_OFFSET = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS_SHOWN  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLS_SHOWN  = 3'd4;

  localparam logic [13:0] RST_TEXT_START  = 14'd0;
  localparam logic [7:0]  RST_ROW_PITCH   = 8'd80;
  localparam logic [13:0] RST_ATTR_OFFSET = 14'd2048;
  localparam logic [7:0]  RST_ROWS_SHOWN  = 8'd25;
  localparam logic [7:0]  RST_COLS_SHOWN  = 8'd80;

  localparam logic [2:0] ACT_TTY    = 3'd0;
  localparam logic [2:0] ACT_SETCUR = 3'd1;
  localparam logic [2:0] ACT_READ   = 3'd2;
  localparam logic [2:0] ACT_RUN    = 3'd3;
  localparam logic [2:0] ACT_RUNA   = 3'd4;
  localparam logic [2:0] ACT_SCRUP  = 3'd5;
  localparam logic [2:0] ACT_SCRDN  = 3'd6;

  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] BLANK_ATTR = 8'h0E;

  typedef enum logic [3:0] {
    OP_BS, OP_CR, OP_LF, OP_PUT, OP_SETCUR, OP_READ,
    OP_RUN, OP_RUNA, OP_SCRUP, OP_SCRDN, OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  ch;
    logic [3:0]  attr;
    logic [7:0]  c0;
    logic [7:0]  r0;
    logic [7:0]  c1;
    logic [7:0]  r1;
    logic [13:0] count;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } stat_t;

  function automatic logic [3:0] to_rgbi(input logic [7:0] a);
    return {a[2:0], a[3]};
  endfunction

  function automatic logic [3:0] to_irgb(input logic [7:0] s);
    logic [7:0] t;
    t = {1'b0, s[7:1]} + {4'b0, s[0], 3'b0};
    return t[3:0];
  endfunction

endpackage
`default_nettype wire

[design/tcte_if.sv]
// Handshake channels of the console engine: input items, results, config writes.
// No dependencies.
`default_nettype none
interface tcte_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  char_code;
  logic [7:0]  attr;
  logic [7:0]  col;
  logic [7:0]  row;
  logic [7:0]  col_end;
  logic [7:0]  row_end;
  logic [13:0] count;
  modport source (output valid, action, char_code, attr, col, row, col_end, row_end, count,
                  input ready);
  modport sink (input valid, action, char_code, attr, col, row, col_end, row_end, count,
                output ready);
endinterface

interface tcte_res_if;
  logic        valid;
  logic        ready;
  logic [13:0] cursor_addr;
  logic [7:0]  read_char;
  logic [3:0]  read_attr;
  modport source (output valid, cursor_addr, read_char, read_attr, input ready);
  modport sink (input valid, cursor_addr, read_char, read_attr, output ready);
endinterface

interface tcte_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/tcte_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module tcte_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [W-1:0]             wdata_i,
  output logic      [W-1:0]             rdata_o
);
  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

[design/tcte_front.sv]
// Front end: accepts input beats, classifies them into commands, short command queue.
// Depends on tcte_pkg and tcte_if.
`default_nettype none
module tcte_front
  import tcte_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcte_in_if.sink   inp_i,
  input  wire logic clearing_i,
  output logic      cmd_valid_o,
  input  wire logic cmd_ready_i,
  output cmd_t      cmd_o
);
  localparam int QAW = $clog2(CMD_QUEUE_DEPTH);

  cmd_t            mem_q [CMD_QUEUE_DEPTH];
  logic [QAW-1:0]  wr_q, rd_q;
  logic [QAW:0]    cnt_q;
  cmd_t            cls;
  logic            push, pop;

  always_comb begin
    cls.ch    = inp_i.char_code;
    cls.attr  = to_rgbi(inp_i.attr);
    cls.c0    = inp_i.col;
    cls.r0    = inp_i.row;
    cls.c1    = inp_i.col_end;
    cls.r1    = inp_i.row_end;
    cls.count = inp_i.count;
    case (inp_i.action)
      ACT_TTY: begin
        if (inp_i.char_code == CH_BS) cls.op = OP_BS;
        else if (inp_i.char_code == CH_CR) cls.op = OP_CR;
        else if (inp_i.char_code == CH_LF) cls.op = OP_LF;
        else cls.op = OP_PUT;
      end
      ACT_SETCUR: cls.op = OP_SETCUR;
      ACT_READ:   cls.op = OP_READ;
      ACT_RUN:    cls.op = OP_RUN;
      ACT_RUNA:   cls.op = OP_RUNA;
      ACT_SCRUP:  cls.op = OP_SCRUP;
      ACT_SCRDN:  cls.op = OP_SCRDN;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign inp_i.ready = !clearing_i && (cnt_q != (QAW+1)'(CMD_QUEUE_DEPTH));
  assign push        = inp_i.valid && inp_i.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + QAW'(1);
      if (pop) rd_q <= rd_q + QAW'(1);
      if (push && !pop) cnt_q <= cnt_q + (QAW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (QAW+1)'(1);
    end
  end
endmodule
`default_nettype wire

[design/tcte_back.sv]
// Back end: sequencer that runs commands on the video store, holds cursor and config.
// Depends on tcte_pkg, tcte_if and tcte_ram.
`default_nettype none
module tcte_back
  import tcte_pkg::*;
#(
  parameter int STORE_ADDR_BITS = STORE_ADDR_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  output logic       cmd_ready_o,
  input  wire cmd_t  cmd_i,
  tcte_cfg_if.sink   cfg_i,
  tcte_res_if.source res_o,
  output stat_t      stat_o
);
  localparam int AW = STORE_ADDR_BITS;
  localparam int PW = AW + 9;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CA0    = 5'd2;
  localparam logic [4:0] S_CA1    = 5'd3;
  localparam logic [4:0] S_EXEC   = 5'd4;
  localparam logic [4:0] S_PUTA   = 5'd5;
  localparam logic [4:0] S_RDA    = 5'd6;
  localparam logic [4:0] S_RDW    = 5'd7;
  localparam logic [4:0] S_FILL   = 5'd8;
  localparam logic [4:0] S_SC0    = 5'd9;
  localparam logic [4:0] S_SC1    = 5'd10;
  localparam logic [4:0] S_SC2    = 5'd11;
  localparam logic [4:0] S_SC3    = 5'd12;
  localparam logic [4:0] S_ROW    = 5'd13;
  localparam logic [4:0] S_CPR    = 5'd14;
  localparam logic [4:0] S_CPW    = 5'd15;
  localparam logic [4:0] S_ROWEND = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  logic [4:0]    state_q;
  logic [13:0]   start_q, off_q;
  logic [7:0]    pitch_q, rows_q, cols_q;
  logic [7:0]    ccol_q, crow_q;
  op_e           op_q;
  logic [7:0]    ch_q;
  logic [3:0]    attr_q;
  logic [7:0]    c0_q, r0_q, c1_q, r1_q;
  logic [13:0]   lines_q;
  logic          up_q, fin_q, scr_q, pend_q, ph_q;
  logic [15:0]   prod_q;
  logic [AW-1:0] base_q, to_q, from_q, step_q, prod2_q, dst_q, src_q, clr_q;
  logic [8:0]    width_q, blank_q, moved_q;
  logic [13:0]   cnt_q;
  logic [7:0]    val_q, rch_q;
  logic [3:0]    rat_q;
  logic          out_v_q;
  logic [13:0]   out_addr_q;
  logic [7:0]    out_ch_q;
  logic [3:0]    out_at_q;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [15:0]   prod_row;
  logic [AW-1:0] cell_d;
  logic [8:0]    h_d, w_d;
  logic [7:0]    nr_d;
  logic [PW-1:0] p2;
  logic [AW-1:0] offa;

  assign offa = AW'(off_q);
  assign nr_d = crow_q + 8'd1;
  assign h_d  = {1'b0, r1_q} - {1'b0, r0_q} + 9'd1;
  assign w_d  = {1'b0, c1_q} - {1'b0, c0_q} + 9'd1;
  assign p2   = PW'(step_q) * PW'(blank_q);

  always_comb begin
    if (state_q == S_SC0) begin
      prod_row = {8'b0, (up_q ? r0_q : r1_q)} * {8'b0, pitch_q};
    end else begin
      prod_row = {8'b0, crow_q} * {8'b0, pitch_q};
    end
  end

  always_comb begin
    if (state_q == S_SC1) begin
      cell_d = AW'(32'(start_q) + 32'(prod_q) + 32'(c0_q));
    end else begin
      cell_d = AW'(32'(start_q) + 32'(prod_q) + 32'(ccol_q));
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = src_q;
    ram_wdata = val_q;
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = 8'd0;
      end
      S_EXEC: begin
        ram_addr  = base_q;
        ram_we    = (op_q == OP_PUT);
        ram_wdata = ch_q;
      end
      S_PUTA: begin
        ram_we    = 1'b1;
        ram_addr  = base_q + offa;
        ram_wdata = {4'b0, attr_q};
      end
      S_RDA:  ram_addr = base_q + offa;
      S_FILL: begin
        ram_we   = (cnt_q != '0);
        ram_addr = dst_q;
      end
      S_CPW: begin
        ram_we    = 1'b1;
        ram_addr  = dst_q;
        ram_wdata = ram_rdata;
      end
      default: ram_addr = src_q;
    endcase
  end

  tcte_ram #(.W(8), .DEPTH(2 ** AW)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign cmd_ready_o     = (state_q == S_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign res_o.valid       = out_v_q;
  assign res_o.cursor_addr = out_addr_q;
  assign res_o.read_char   = out_ch_q;
  assign res_o.read_attr   = out_at_q;
  assign stat_o.clearing = (state_q == S_CLR);
  assign stat_o.idle     = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= RST_TEXT_START;
      pitch_q <= RST_ROW_PITCH;
      off_q   <= RST_ATTR_OFFSET;
      rows_q  <= RST_ROWS_SHOWN;
      cols_q  <= RST_COLS_SHOWN;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TEXT_START:  start_q <= cfg_i.data;
        REG_ROW_PITCH:   pitch_q <= cfg_i.data[7:0];
        REG_ATTR_OFFSET: off_q   <= cfg_i.data;
        REG_ROWS_SHOWN:  rows_q  <= cfg_i.data[7:0];
        REG_COLS_SHOWN:  cols_q  <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q    <= cmd_i.op;
        ch_q    <= cmd_i.ch;
        attr_q  <= cmd_i.attr;
        c0_q    <= cmd_i.c0;
        r0_q    <= cmd_i.r0;
        c1_q    <= cmd_i.c1;
        r1_q    <= cmd_i.r1;
        lines_q <= cmd_i.count;
        up_q    <= (cmd_i.op != OP_SCRDN);
        rch_q   <= 8'd0;
        rat_q   <= 4'd0;
        if (cmd_i.op == OP_LF) begin
          c0_q    <= 8'd0;
          r0_q    <= 8'd0;
          c1_q    <= cols_q - 8'd1;
          r1_q    <= rows_q - 8'd1;
          lines_q <= 14'd1;
        end
      end
      S_CA0: prod_q <= prod_row;
      S_CA1: base_q <= cell_d;
      S_EXEC: begin
        cnt_q <= lines_q;
        scr_q <= 1'b0;
        if (op_q == OP_RUNA) begin
          dst_q  <= base_q + offa;
          val_q  <= {4'b0, attr_q};
          pend_q <= 1'b1;
        end else begin
          dst_q  <= base_q;
          val_q  <= ch_q;
          pend_q <= 1'b0;
        end
      end
      S_RDA: rch_q <= ram_rdata;
      S_RDW: rat_q <= to_irgb(ram_rdata);
      S_FILL: begin
        if (cnt_q != '0) begin
          dst_q <= dst_q + AW'(1);
          cnt_q <= cnt_q - 14'd1;
        end else if (pend_q) begin
          pend_q <= 1'b0;
          dst_q  <= base_q;
          val_q  <= ch_q;
          cnt_q  <= lines_q;
        end
      end
      S_SC0: begin
        prod_q  <= prod_row;
        width_q <= w_d;
        if (lines_q == '0 || lines_q >= 14'(h_d)) begin
          blank_q <= h_d;
          moved_q <= 9'd0;
        end else begin
          blank_q <= 9'(lines_q);
          moved_q <= h_d - 9'(lines_q);
        end
      end
      S_SC1: begin
        to_q   <= cell_d;
        step_q <= up_q ? AW'(pitch_q) : AW'(0) - AW'(pitch_q);
      end
      S_SC2: prod2_q <= AW'(p2);
      S_SC3: begin
        from_q <= to_q + prod2_q;
        ph_q   <= 1'b0;
        scr_q  <= 1'b1;
        pend_q <= 1'b0;
      end
      S_ROW: begin
        dst_q <= to_q + (ph_q ? offa : '0);
        src_q <= from_q + (ph_q ? offa : '0);
        cnt_q <= 14'(width_q);
        val_q <= ph_q ? BLANK_ATTR : BLANK_CHAR;
      end
      S_CPW: begin
        dst_q <= dst_q + AW'(1);
        src_q <= src_q + AW'(1);
        cnt_q <= cnt_q - 14'd1;
      end
      S_ROWEND: begin
        ph_q <= !ph_q;
        if (ph_q) begin
          to_q <= to_q + step_q;
          if (moved_q != '0) begin
            moved_q <= moved_q - 9'd1;
            from_q  <= from_q + step_q;
          end else begin
            blank_q <= blank_q - 9'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      ccol_q     <= 8'd0;
      crow_q     <= 8'd0;
      fin_q      <= 1'b0;
      out_v_q    <= 1'b0;
      out_addr_q <= '0;
      out_ch_q   <= '0;
      out_at_q   <= '0;
    end else begin
      if (res_o.valid && res_o.ready && (state_q != S_OUT)) out_v_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            fin_q   <= 1'b1;
            state_q <= S_CA0;
            case (cmd_i.op)
              OP_BS: if (ccol_q != 8'd0) ccol_q <= ccol_q - 8'd1;
              OP_CR: ccol_q <= 8'd0;
              OP_LF: begin
                if (nr_d < rows_q) crow_q <= nr_d;
                else state_q <= S_SC0;
              end
              OP_SETCUR: begin
                ccol_q <= cmd_i.c0;
                crow_q <= cmd_i.r0;
              end
              OP_PUT, OP_READ, OP_RUN, OP_RUNA: fin_q <= 1'b0;
              OP_SCRUP, OP_SCRDN: state_q <= S_SC0;
              default: ;
            endcase
          end
        end
        S_CA0: state_q <= S_CA1;
        S_CA1: state_q <= fin_q ? S_OUT : S_EXEC;
        S_EXEC: begin
          case (op_q)
            OP_PUT:  state_q <= S_PUTA;
            OP_READ: state_q <= S_RDA;
            default: state_q <= S_FILL;
          endcase
        end
        S_PUTA: begin
          ccol_q  <= ccol_q + 8'd1;
          fin_q   <= 1'b1;
          state_q <= S_CA0;
        end
        S_RDA: state_q <= S_RDW;
        S_RDW: begin
          fin_q   <= 1'b1;
          state_q <= S_CA0;
        end
        S_FILL: begin
          if (cnt_q == '0) begin
            if (scr_q) begin
              state_q <= S_ROWEND;
            end else if (!pend_q) begin
              fin_q   <= 1'b1;
              state_q <= S_CA0;
            end
          end
        end
        S_SC0: begin
          if (c1_q < c0_q || r1_q < r0_q) begin
            fin_q   <= 1'b1;
            state_q <= S_CA0;
          end else begin
            state_q <= S_SC1;
          end
        end
        S_SC1: state_q <= S_SC2;
        S_SC2: state_q <= S_SC3;
        S_SC3: state_q <= S_ROW;
        S_ROW: begin
          if (moved_q != '0) begin
            state_q <= S_CPR;
          end else if (blank_q != '0) begin
            state_q <= S_FILL;
          end else begin
            fin_q   <= 1'b1;
            state_q <= S_CA0;
          end
        end
        S_CPR: state_q <= (cnt_q == '0) ? S_ROWEND : S_CPW;
        S_CPW: state_q <= S_CPR;
        S_ROWEND: state_q <= S_ROW;
        S_OUT: begin
          if (!out_v_q || res_o.ready) begin
            out_v_q    <= 1'b1;
            out_addr_q <= 14'(base_q);
            out_ch_q   <= rch_q;
            out_at_q   <= rat_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/text_console_teletype_engine_top.sv]
// Top level of the text console teletype engine: front end, queue and back end.
// Depends on tcte_pkg, tcte_if, tcte_front, tcte_back (with tcte_ram).
//
// Channels: inp_i takes one action per beat (valid/ready); res_o returns one
// result beat per action in order; cfg_i writes a register per beat, only while idle,
// which the user must keep to and the block itself does not enforce. After reset the
// video store is cleared to zero, one cell per cycle; inp_i.ready stays low meanwhile
// (cfg writes are taken). A beat enters a two-entry command queue; the back-end
// sequencer runs one command at a time over the single-port store, one store access
// per cycle: cursor moves and set cursor update the cursor; a character write stores
// the character, then its attribute; a read fetches both; runs fill count cells,
// attributes first where asked; a scroll copies moved rows and blanks the rest.
// The result sits in an output register; if the receiver stalls, the sequencer
// holds the next result and the queue keeps taking beats until full.
`default_nettype none
module text_console_teletype_engine_top
  import tcte_pkg::*;
#(
  parameter int STORE_ADDR_BITS = STORE_ADDR_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcte_in_if.sink    inp_i,
  tcte_cfg_if.sink   cfg_i,
  tcte_res_if.source res_o
);
  logic  cmd_valid, cmd_ready;
  cmd_t  cmd;
  stat_t stat;

  tcte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .inp_i      (inp_i),
    .clearing_i (stat.clearing),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  tcte_back #(.STORE_ADDR_BITS(STORE_ADDR_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .cfg_i      (cfg_i),
    .res_o      (res_o),
    .stat_o     (stat)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !inp_i.ready && !cmd_ready)
    else $error("command taken during store clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> !stat.idle)
    else $error("sequencer stayed idle after taking a command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !res_o.valid)
    else $error("result produced during store clear");
endmodule
`default_nettype wire
